>>> rtl/serial_frame_sync_crc_checker_macros.svh
// Assertion macros for the serial frame sync / CRC checker.
// Included by the top level; needs nothing else.
`ifndef SERIAL_FRAME_SYNC_CRC_CHECKER_MACROS_SVH
`define SERIAL_FRAME_SYNC_CRC_CHECKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfsc: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfsc: next-cycle check failed");

`endif

>>> rtl/sfsc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the frame checker.
// No dependencies.
`default_nettype none

package sfsc_pkg;

    localparam int unsigned HDR_BYTES   = 6;
    localparam int unsigned CNT_W       = 17;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SYNC_FIRST  = 2'd0;
    localparam t_cfg_index CFG_SYNC_SECOND = 2'd1;
    localparam t_cfg_index CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0]  RST_SYNC_FIRST  = 8'h5A;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'hA5;
    localparam logic [15:0] RST_MAX_PAYLOAD = 16'd250;

    typedef logic [1:0] t_status;
    localparam t_status ST_NONE    = 2'd0;
    localparam t_status ST_OK      = 2'd1;
    localparam t_status ST_LEN_ERR = 2'd2;
    localparam t_status ST_CRC_ERR = 2'd3;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_status     frame_status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } t_result;

    // CRC-16, MSB first, no reflection
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/serial_frame_sync_crc_checker.sv
// Serial frame deframer: sync hunt, length check, CRC-16 check, payload out.
// Depends on sfsc_pkg, sfsc_deframe and serial_frame_sync_crc_checker_macros.svh.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------------
//   byte in  | in        | i_valid / o_stall      | i_data_byte
//   result   | out       | o_valid / i_stall      | o_frame_status, o_payload_*
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One byte per cycle while o_stall is low; each byte is decoded in the cycle it is taken
// and its result is registered into the output register, or the skid entry if stalled.
// A two-entry output stage (register plus skid) keeps o_stall registered; the
// input stalls only while the skid entry is occupied.
// Reset (synchronous, active low) returns to sync hunt with default config.
`default_nettype none

`include "serial_frame_sync_crc_checker_macros.svh"

module serial_frame_sync_crc_checker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire  [7:0]                i_data_byte,
    output logic                      o_valid,
    input  wire                       i_stall,
    output sfsc_pkg::t_status         o_frame_status,
    output logic                      o_payload_valid,
    output logic [7:0]                o_payload_byte,
    output logic [15:0]               o_payload_offset,
    output logic [15:0]               o_payload_length,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  sfsc_pkg::t_cfg_index i_cfg_index,
    input  wire  [15:0]               i_cfg_data
);
    import sfsc_pkg::*;

    t_cfg    r_cfg;
    t_result dec_res;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    in_fire, out_free;
    logic    out_pay;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign in_fire     = i_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= RST_SYNC_FIRST;
            r_cfg.sync_second <= RST_SYNC_SECOND;
            r_cfg.max_payload <= RST_MAX_PAYLOAD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfsc_deframe u_deframe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_fire),
        .i_byte  (i_data_byte),
        .i_cfg   (r_cfg),
        .o_res   (dec_res)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : dec_res;
        end else if (in_fire) begin
            r_skid <= dec_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_status   = r_out.frame_status;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_offset = r_out.payload_offset;
    assign o_payload_length = r_out.payload_length;

    assign out_pay = o_valid && o_payload_valid;

    `SFSC_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SFSC_ASSERT_NEXT(a_blocked_take_to_skid, i_clk, i_rst_n, in_fire && !out_free, r_skid_valid)
    `SFSC_ASSERT_NOW(a_payload_no_len_err, i_clk, i_rst_n, out_pay, o_frame_status != ST_LEN_ERR)
    `SFSC_ASSERT_NOW(a_offset_lt_len, i_clk, i_rst_n, out_pay, o_payload_offset < o_payload_length)

endmodule

`default_nettype wire

>>> rtl/sfsc_deframe.sv
// Frame state and per-byte decode: sync hunt, header, payload, CRC verdict.
// Depends on sfsc_pkg.
`default_nettype none

module sfsc_deframe (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_take,
    input  wire  [7:0]             i_byte,
    input  wire  sfsc_pkg::t_cfg   i_cfg,
    output sfsc_pkg::t_result      o_res
);
    import sfsc_pkg::*;

    logic [7:0]       r_prev,    n_prev;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [15:0]      r_len,     n_len;
    logic [15:0]      r_crc_run, n_crc_run;
    logic [15:0]      r_crc_rx,  n_crc_rx;

    logic [CNT_W:0]   cnt_inc;
    logic [CNT_W:0]   frame_end;
    logic [15:0]      offs;

    assign cnt_inc   = {1'b0, r_cnt} + 1'b1;
    assign frame_end = (CNT_W + 1)'(r_len) + (CNT_W + 1)'(HDR_BYTES);
    assign offs      = r_cnt[15:0] - 16'(HDR_BYTES);

    always_comb begin
        n_prev    = r_prev;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_crc_run = r_crc_run;
        n_crc_rx  = r_crc_rx;
        o_res     = '0;

        priority if (r_cnt == '0) begin
            n_prev = i_byte;
            if (r_prev == i_cfg.sync_first && i_byte == i_cfg.sync_second) begin
                n_cnt     = CNT_W'(2);
                n_len     = '0;
                n_crc_rx  = '0;
                n_crc_run = crc_byte(crc_byte(16'h0000, i_cfg.sync_first),
                                     i_cfg.sync_second);
            end
        end else if (r_cnt < CNT_W'(HDR_BYTES)) begin
            n_cnt = cnt_inc[CNT_W-1:0];
            unique case (r_cnt[2:0])
                3'd2: begin
                    n_len     = {r_len[15:8], i_byte};
                    n_crc_run = crc_byte(r_crc_run, i_byte);
                end
                3'd3: begin
                    n_len     = {i_byte, r_len[7:0]};
                    n_crc_run = crc_byte(r_crc_run, i_byte);
                end
                3'd4: n_crc_rx = {r_crc_rx[15:8], i_byte};
                default: n_crc_rx = {i_byte, r_crc_rx[7:0]};
            endcase
            // header complete: length check, or verdict for an empty payload
            if (r_cnt == CNT_W'(HDR_BYTES - 1)) begin
                if (r_len > i_cfg.max_payload) begin
                    o_res.frame_status = ST_LEN_ERR;
                    n_cnt              = '0;
                end else if (r_len == '0) begin
                    o_res.frame_status = (r_crc_run == n_crc_rx) ? ST_OK : ST_CRC_ERR;
                    n_cnt              = '0;
                end
            end
        end else begin
            o_res.payload_valid  = 1'b1;
            o_res.payload_byte   = i_byte;
            o_res.payload_offset = offs;
            n_crc_run            = crc_byte(r_crc_run, i_byte);
            n_cnt                = cnt_inc[CNT_W-1:0];
            if (cnt_inc >= frame_end) begin
                o_res.frame_status = (n_crc_run == r_crc_rx) ? ST_OK : ST_CRC_ERR;
                n_cnt              = '0;
            end
        end
        o_res.payload_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_crc_run <= '0;
            r_crc_rx  <= '0;
        end else if (i_take) begin
            r_prev    <= n_prev;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_crc_run <= n_crc_run;
            r_crc_rx  <= n_crc_rx;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/frame_result_checker.sv
// Result checker for serial_frame_sync_crc_checker: watches the byte, result and register
// channels, decodes every accepted byte on its own and compares the results field by field.
// Depends on sfsc_pkg for the port types, register indexes and status codes.
`timescale 1ns / 100ps

module frame_result_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  o_stall,
    input  wire  [7:0]           i_data_byte,
    input  wire                  o_valid,
    input  wire                  i_stall,
    input  sfsc_pkg::t_status    o_frame_status,
    input  wire                  o_payload_valid,
    input  wire  [7:0]           o_payload_byte,
    input  wire  [15:0]          o_payload_offset,
    input  wire  [15:0]          o_payload_length,
    input  wire                  i_cfg_valid,
    input  wire                  o_cfg_ready,
    input  sfsc_pkg::t_cfg_index i_cfg_index,
    input  wire  [15:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending_count
);
    import sfsc_pkg::*;

    localparam logic [16:0] LEN_LO_POS = 17'd2;
    localparam logic [16:0] LEN_HI_POS = 17'd3;
    localparam logic [16:0] CRC_LO_POS = 17'd4;
    localparam logic [16:0] HDR_LEN    = 17'(HDR_BYTES);

    // register copies
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [15:0] max_len;

    // deframer state
    logic [7:0]  hunt_byte;
    logic [16:0] frame_pos;
    logic [15:0] frame_len;
    logic [15:0] crc_acc;
    logic [15:0] crc_field;

    t_result pending_decodes[$];

    // bit-serial CRC-16, poly 0x1021, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_status crc_verdict();
        return (crc_acc == crc_field) ? ST_OK : ST_CRC_ERR;
    endfunction

    task automatic decode_byte(input logic [7:0] d, output t_result r);
        r = '0;
        if (frame_pos == 17'd0) begin
            if (hunt_byte == sync_a && d == sync_b) begin
                frame_pos = LEN_LO_POS;
                frame_len = 16'h0000;
                crc_field = 16'h0000;
                crc_acc   = crc16_step(crc16_step(16'h0000, sync_a), sync_b);
            end
            hunt_byte = d;
        end else if (frame_pos < HDR_LEN) begin
            case (frame_pos)
                LEN_LO_POS: begin
                    frame_len[7:0] = d;
                    crc_acc = crc16_step(crc_acc, d);
                end
                LEN_HI_POS: begin
                    frame_len[15:8] = d;
                    crc_acc = crc16_step(crc_acc, d);
                end
                CRC_LO_POS: crc_field[7:0] = d;
                default:    crc_field[15:8] = d;
            endcase
            frame_pos = frame_pos + 17'd1;
            // header complete: length check, or verdict for an empty payload
            if (frame_pos == HDR_LEN) begin
                if (frame_len > max_len) begin
                    r.frame_status = ST_LEN_ERR;
                    frame_pos = 17'd0;
                end else if (frame_len == 16'h0000) begin
                    r.frame_status = crc_verdict();
                    frame_pos = 17'd0;
                end
            end
        end else begin
            r.payload_valid  = 1'b1;
            r.payload_byte   = d;
            r.payload_offset = 16'(frame_pos - HDR_LEN);
            crc_acc   = crc16_step(crc_acc, d);
            frame_pos = frame_pos + 17'd1;
            if (frame_pos >= {1'b0, frame_len} + HDR_LEN) begin
                r.frame_status = crc_verdict();
                frame_pos = 17'd0;
            end
        end
        r.payload_length = frame_len;
    endtask

    function automatic int field_mismatch(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int      fails_now;
        fails_now = 0;
        if (!i_rst_n) begin
            sync_a    = RST_SYNC_FIRST;
            sync_b    = RST_SYNC_SECOND;
            max_len   = RST_MAX_PAYLOAD;
            hunt_byte = 8'h00;
            frame_pos = 17'd0;
            frame_len = 16'h0000;
            crc_acc   = 16'h0000;
            crc_field = 16'h0000;
            pending_decodes.delete();
        end else begin
            // a result never belongs to the byte taken at the same edge
            if (o_valid && !i_stall) begin
                if (pending_decodes.size() == 0) begin
                    $error("result with no request outstanding");
                    fails_now = 1;
                end else begin
                    want = pending_decodes.pop_front();
                    fails_now += field_mismatch("frame_status", 16'(want.frame_status),
                                                16'(o_frame_status));
                    fails_now += field_mismatch("payload_valid", 16'(want.payload_valid),
                                                16'(o_payload_valid));
                    fails_now += field_mismatch("payload_byte", 16'(want.payload_byte),
                                                16'(o_payload_byte));
                    fails_now += field_mismatch("payload_offset", want.payload_offset,
                                                o_payload_offset);
                    fails_now += field_mismatch("payload_length", want.payload_length,
                                                o_payload_length);
                end
            end
            if (i_valid && !o_stall) begin
                decode_byte(i_data_byte, want);
                pending_decodes.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  sync_a  = i_cfg_data[7:0];
                    CFG_SYNC_SECOND: sync_b  = i_cfg_data[7:0];
                    CFG_MAX_PAYLOAD: max_len = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count    <= o_fail_count + fails_now;
        o_pending_count <= pending_decodes.size();
    end

endmodule

>>> tb/sv/tb_serial_frame_sync_crc_checker.sv
// Top of the serial_frame_sync_crc_checker testbench: clock, reset, frame stimulus,
// random idling on both sides, watchdog and verdict. Depends on sfsc_pkg, the block
// and frame_result_checker.
`timescale 1ns / 100ps

module tb_serial_frame_sync_crc_checker;
    import sfsc_pkg::*;

    localparam t_cfg_index CFG_SPARE   = 2'd3;
    localparam int         STALL_LIMIT = 1000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_stall      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    t_cfg_index  i_cfg_index  = CFG_SYNC_FIRST;
    logic [15:0] i_cfg_data   = 16'h0000;

    logic        o_stall;
    logic        o_valid;
    t_status     o_frame_status;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_offset;
    logic [15:0] o_payload_length;
    logic        o_cfg_ready;

    int          fail_count;
    int          pending_count;

    // register values as the stimulus sees them
    logic [7:0]  tx_sync_a  = RST_SYNC_FIRST;
    logic [7:0]  tx_sync_b  = RST_SYNC_SECOND;
    logic [15:0] tx_max_len = RST_MAX_PAYLOAD;

    logic        quiet       = 1'b0;
    int          bytes_sent  = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    serial_frame_sync_crc_checker DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_payload_valid  (o_payload_valid),
        .o_payload_byte   (o_payload_byte),
        .o_payload_offset (o_payload_offset),
        .o_payload_length (o_payload_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    frame_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_payload_valid  (o_payload_valid),
        .o_payload_byte   (o_payload_byte),
        .o_payload_offset (o_payload_offset),
        .o_payload_length (o_payload_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid stays high on return so back-to-back bytes need no extra edge
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // an overlong frame is cut off after its header
    task automatic send_frame(input logic [15:0] len, input bit corrupt);
        logic [7:0]  body[$];
        logic [15:0] crc;
        body = {};
        if (len <= tx_max_len) begin
            for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        end
        crc = crc_byte(16'h0000, tx_sync_a);
        crc = crc_byte(crc, tx_sync_b);
        crc = crc_byte(crc, len[7:0]);
        crc = crc_byte(crc, len[15:8]);
        foreach (body[i]) crc = crc_byte(crc, body[i]);
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        send_byte(tx_sync_a);
        send_byte(tx_sync_b);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[i]) send_byte(body[i]);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] sa, input logic [7:0] sb,
                              input logic [15:0] max_len);
        wait_results();
        write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_SYNC_FIRST, {8'($urandom), sa});
        write_reg(CFG_SYNC_SECOND, {8'($urandom), sb});
        write_reg(CFG_MAX_PAYLOAD, max_len);
        i_cfg_valid <= 1'b0;
        tx_sync_a  = sa;
        tx_sync_b  = sb;
        tx_max_len = max_len;
    endtask

    // mostly good frames, with bad CRCs, overlong lengths and line noise mixed in
    task automatic random_traffic(input int count);
        int target;
        int pick;
        int cap;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            cap  = ($urandom_range(0, 15) == 0) ? 60 : 12;
            if (cap > int'(tx_max_len)) cap = int'(tx_max_len);
            if (pick < 65) begin
                send_frame(16'($urandom_range(0, cap)), 1'b0);
            end else if (pick < 78) begin
                send_frame(16'($urandom_range(0, cap)), 1'b1);
            end else if (pick < 88 && tx_max_len != 16'hFFFF) begin
                send_frame(16'($urandom_range(int'(tx_max_len) + 1, 65535)), 1'b0);
            end else begin
                if ($urandom_range(0, 1) == 1) send_byte(tx_sync_a);
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: empty payload good and bad, one-byte payload, overlong length
        send_frame(16'd0, 1'b0);
        send_frame(16'd0, 1'b1);
        send_frame(16'd1, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        random_traffic(250);

        set_config(8'h00, 8'hFF, 16'd0);
        random_traffic(200);

        set_config(8'hFF, 8'h00, 16'hFFFF);
        send_frame(16'd300, 1'b0);
        random_traffic(250);

        // identical sync bytes
        set_config(8'h3C, 8'h3C, 16'd20);
        quiet <= 1'b1;
        random_traffic(80);
        quiet <= 1'b0;

        set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 64)));
        random_traffic(100);

        set_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MAX_PAYLOAD);
        random_traffic(200);
        quiet <= 1'b1;
        random_traffic(170);

        wait_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
